// ===== hw/rtl/skst_pkg.sv =====
// Shared types and constants for the sorted keyed score table.
package skst_pkg;

    localparam int CAPACITY  = 16;
    localparam int ID_W      = 24;
    localparam int SCORE_W   = 8;
    localparam int POS_W     = 4;
    localparam int COUNT_W   = 5;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef logic [ID_W-1:0]    id_t;
    typedef logic [SCORE_W-1:0] score_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_DUPLICATE = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic   ins_en;
        logic   upd_en;
        logic   del_en;
        id_t    id;
        score_t score;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/sorted_keyed_score_table_unit.sv =====
// Sorted keyed score table: command control, output register and the chain of slot cells.
// Insert, update, delete: one result each; the next command is taken once that result is loaded for output.
// Dump: entries stream out of the dump state, one per cycle while the output is not stalled (empty table: one).
// A command passes the command register and the chain execute step before its result is registered for output.
// Output stalls hold the execute step; a new command is taken while a result waits.
// Reset (rst_n low, async) empties the table and the output; slot contents stay undefined.
module sorted_keyed_score_table_unit
    import skst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // id[23:0], score[31:24]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[1:0], entry_id[25:2], entry_score[33:26],
                                   // position[37:34], entry_count[42:38], valid_res[43], zero pad
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DUMP = 3'b100
    } state_t;

    typedef struct packed {
        status_t              status;
        id_t                  entry_id;
        score_t               entry_score;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   entry_count;
        logic                 valid_res;
        logic                 last;
    } res_t;

    state_t    state_reg;
    state_t    state_next;
    cmd_t      cmd_reg;
    id_t       key_id_reg;
    score_t    key_score_reg;
    cnt_t      count_reg;
    cnt_t      count_next;
    idx_t      dump_idx_reg;
    idx_t      dump_idx_next;
    res_t      res_reg;
    res_t      res_next;
    logic      out_valid_reg;
    logic      out_load;
    logic      out_free;

    cell_ctl_t               ctl;
    id_t                     cell_id    [CAPACITY];
    score_t                  cell_score [CAPACITY];
    logic [CAPACITY-1:0]     match_vec;
    logic [CAPACITY-1:0]     ins_vec;
    logic [CAPACITY:0]       scan_chain;
    logic [CAPACITY:0]       del_chain;

    logic   found;
    logic   full;
    idx_t   match_pos;
    idx_t   ins_pos;
    score_t match_score;
    logic   dump_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // ---- cell chain ----
    assign scan_chain[0] = 1'b1;
    assign del_chain[0]  = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        skst_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .head        ((i == 0) ? 1'b1 : 1'b0),
            .occ         (CNT_W'(i) < count_reg),
            .scan_in     (scan_chain[i]),
            .del_in      (del_chain[i]),
            .left_id     ((i == 0) ? key_id_reg : cell_id[(i == 0) ? 0 : i - 1]),
            .left_score  ((i == 0) ? key_score_reg : cell_score[(i == 0) ? 0 : i - 1]),
            .right_id    ((i == CAPACITY - 1) ? id_t'(0) :
                          cell_id[(i == CAPACITY - 1) ? i : i + 1]),
            .right_score ((i == CAPACITY - 1) ? score_t'(0) :
                          cell_score[(i == CAPACITY - 1) ? i : i + 1]),
            .id          (cell_id[i]),
            .score       (cell_score[i]),
            .match       (match_vec[i]),
            .scan_out    (scan_chain[i+1]),
            .del_out     (del_chain[i+1]),
            .ins_here    (ins_vec[i])
        );
    end

    // ---- lookup summaries (match and insert point each have at most one bit set) ----
    always_comb
    begin
        match_pos   = '0;
        ins_pos     = '0;
        match_score = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_vec[i])
            begin
                match_pos   = match_pos | idx_t'(i);
                match_score = match_score | cell_score[i];
            end
            if (ins_vec[i])
            begin
                ins_pos = ins_pos | idx_t'(i);
            end
        end
    end

    assign found     = |match_vec;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign dump_last = ({1'b0, dump_idx_reg} == (count_reg - cnt_t'(1)));

    // ---- control ----
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        dump_idx_next    = dump_idx_reg;
        out_load         = 1'b0;
        ctl.ins_en       = 1'b0;
        ctl.upd_en       = 1'b0;
        ctl.del_en       = 1'b0;
        ctl.id           = key_id_reg;
        ctl.score        = key_score_reg;
        res_next.status      = STS_OK;
        res_next.entry_id    = key_id_reg;
        res_next.entry_score = '0;
        res_next.position    = '0;
        res_next.entry_count = COUNT_W'(count_reg);
        res_next.valid_res   = 1'b0;
        res_next.last        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (found)
                            begin
                                res_next.status      = STS_DUPLICATE;
                                res_next.entry_score = match_score;
                                res_next.position    = POS_W'(match_pos);
                                res_next.valid_res   = 1'b1;
                            end
                            else if (full)
                            begin
                                res_next.status = STS_FULL;
                            end
                            else
                            begin
                                ctl.ins_en           = 1'b1;
                                count_next           = count_reg + cnt_t'(1);
                                res_next.entry_score = key_score_reg;
                                res_next.position    = POS_W'(ins_pos);
                                res_next.entry_count = COUNT_W'(count_next);
                                res_next.valid_res   = 1'b1;
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (found)
                            begin
                                ctl.upd_en           = 1'b1;
                                res_next.entry_score = key_score_reg;
                                res_next.position    = POS_W'(match_pos);
                                res_next.valid_res   = 1'b1;
                            end
                            else
                            begin
                                res_next.status = STS_NOT_FOUND;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (found)
                            begin
                                ctl.del_en           = 1'b1;
                                count_next           = count_reg - cnt_t'(1);
                                res_next.entry_score = match_score;
                                res_next.position    = POS_W'(match_pos);
                                res_next.entry_count = COUNT_W'(count_next);
                                res_next.valid_res   = 1'b1;
                            end
                            else
                            begin
                                res_next.status = STS_NOT_FOUND;
                            end
                        end
                        CMD_DUMP:
                        begin
                            res_next.entry_id = '0;
                            if (count_reg != '0)
                            begin
                                // entries stream out of the dump state instead
                                out_load      = 1'b0;
                                dump_idx_next = '0;
                                state_next    = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                res_next.entry_id    = cell_id[dump_idx_reg];
                res_next.entry_score = cell_score[dump_idx_reg];
                res_next.position    = POS_W'(dump_idx_reg);
                res_next.valid_res   = 1'b1;
                res_next.last        = dump_last;
                if (out_free)
                begin
                    out_load      = 1'b1;
                    dump_idx_next = dump_idx_reg + idx_t'(1);
                    if (dump_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg       <= cmd_t'(s_tuser);
            key_id_reg    <= s_tdata[ID_W-1:0];
            key_score_reg <= s_tdata[ID_W +: SCORE_W];
        end
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {4'b0000, res_reg.valid_res, res_reg.entry_count, res_reg.position,
                       res_reg.entry_score, res_reg.entry_id, res_reg.status};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_unique_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $onehot0(match_vec))
        else $error("id held in more than one slot");

    a_one_ins_point: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins_en |-> $onehot(ins_vec))
        else $error("insert point not unique");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins_en |=> (count_reg == $past(count_reg) + cnt_t'(1)))
        else $error("insert did not grow the table");

    a_dump_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |=> $stable(count_reg))
        else $error("table changed during dump");
`endif

endmodule

// ===== hw/rtl/skst_cell.sv =====
// One slot of the table: compares against the broadcast key and shifts with its neighbors.
module skst_cell
    import skst_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      head,
    input  logic      occ,
    input  logic      scan_in,
    input  logic      del_in,
    input  id_t       left_id,
    input  score_t    left_score,
    input  id_t       right_id,
    input  score_t    right_score,
    output id_t       id,
    output score_t    score,
    output logic      match,
    output logic      scan_out,
    output logic      del_out,
    output logic      ins_here
);

    id_t    id_reg;
    id_t    id_next;
    score_t score_reg;
    score_t score_next;
    logic   cond;

    // The head keeps the new entry out only when its score is not lower.
    assign cond     = occ && (head ? (score_reg >= ctl.score) : (score_reg > ctl.score));
    assign match    = occ && (id_reg == ctl.id);
    assign ins_here = scan_in && !cond;
    assign scan_out = scan_in && cond;
    assign del_out  = del_in || match;

    always_comb
    begin
        id_next    = id_reg;
        score_next = score_reg;
        if (ctl.ins_en)
        begin
            if (ins_here)
            begin
                id_next    = ctl.id;
                score_next = ctl.score;
            end
            else if (!scan_in)
            begin
                id_next    = left_id;
                score_next = left_score;
            end
        end
        if (ctl.upd_en && match)
        begin
            score_next = ctl.score;
        end
        if (ctl.del_en && del_out)
        begin
            id_next    = right_id;
            score_next = right_score;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        score_reg <= score_next;
    end

    assign id    = id_reg;
    assign score = score_reg;

endmodule

// ===== tb/sv/sorted_keyed_score_table_unit_test.sv =====
// Self-checking testbench for the sorted keyed score table unit.
module sorted_keyed_score_table_unit_test;
    import skst_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 24;
    localparam int RAND_ITEMS  = 230;
    localparam int QUIET_ITEMS = 40;
    localparam int DRAIN       = 20;

    typedef struct {
        status_t              status;
        id_t                  entry_id;
        score_t               entry_score;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   entry_count;
        logic                 valid_res;
        logic                 last;
    } table_result_t;

    // Shadow copy of the table; predicts the result stream of every accepted command.
    class table_shadow;
        id_t             held_ids[CAPACITY];
        score_t          held_scores[CAPACITY];
        int              held;
        table_result_t   pending_results[$];
        int              errors;
        int              checked;
        int              full_hits;
        int              peak;
        int              per_cmd[4];

        function new();
            held      = 0;
            errors    = 0;
            checked   = 0;
            full_hits = 0;
            peak      = 0;
            foreach (per_cmd[i]) per_cmd[i] = 0;
        endfunction

        function int locate(id_t id);
            for (int i = 0; i < held; i++)
            begin
                if (held_ids[i] == id) return i;
            end
            return held;
        endfunction

        function void push(status_t st, id_t eid, score_t esc, int pos, logic vld, logic lst);
            table_result_t r;
            r.status      = st;
            r.entry_id    = eid;
            r.entry_score = esc;
            r.position    = pos[POS_W-1:0];
            r.entry_count = held[COUNT_W-1:0];
            r.valid_res   = vld;
            r.last        = lst;
            pending_results.push_back(r);
        endfunction

        function void note_command(cmd_t cmd, id_t id, score_t score);
            int     s;
            int     pos;
            score_t old;
            per_cmd[cmd]++;
            s = locate(id);
            case (cmd)
                CMD_INSERT:
                begin
                    if (s < held)
                        push(STS_DUPLICATE, id, held_scores[s], s, 1'b1, 1'b1);
                    else if (held >= CAPACITY)
                    begin
                        full_hits++;
                        push(STS_FULL, id, '0, 0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        // head wins only on a strictly lower head score
                        if (held == 0 || held_scores[0] < score)
                            pos = 0;
                        else
                        begin
                            pos = 1;
                            while (pos < held && held_scores[pos] > score) pos++;
                        end
                        for (int i = held; i > pos; i--)
                        begin
                            held_ids[i]    = held_ids[i-1];
                            held_scores[i] = held_scores[i-1];
                        end
                        held_ids[pos]    = id;
                        held_scores[pos] = score;
                        held++;
                        if (held > peak) peak = held;
                        push(STS_OK, id, score, pos, 1'b1, 1'b1);
                    end
                end
                CMD_UPDATE:
                begin
                    if (s >= held)
                        push(STS_NOT_FOUND, id, '0, 0, 1'b0, 1'b1);
                    else
                    begin
                        held_scores[s] = score;
                        push(STS_OK, id, score, s, 1'b1, 1'b1);
                    end
                end
                CMD_DELETE:
                begin
                    if (s >= held)
                        push(STS_NOT_FOUND, id, '0, 0, 1'b0, 1'b1);
                    else
                    begin
                        old = held_scores[s];
                        for (int i = s; i + 1 < held; i++)
                        begin
                            held_ids[i]    = held_ids[i+1];
                            held_scores[i] = held_scores[i+1];
                        end
                        held--;
                        push(STS_OK, id, old, s, 1'b1, 1'b1);
                    end
                end
                default:
                begin
                    if (held == 0)
                        push(STS_OK, '0, '0, 0, 1'b0, 1'b1);
                    else
                        for (int i = 0; i < held; i++)
                            push(STS_OK, held_ids[i], held_scores[i], i, 1'b1,
                                 (i + 1 == held));
                end
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(logic [47:0] data, logic last);
            table_result_t w;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %h with nothing expected", data));
                return;
            end
            w = pending_results.pop_front();
            checked++;
            if (data[1:0] !== w.status)
                report($sformatf("status %0d, expected %0d", data[1:0], w.status));
            if (data[25:2] !== w.entry_id)
                report($sformatf("entry_id %h, expected %h", data[25:2], w.entry_id));
            if (data[33:26] !== w.entry_score)
                report($sformatf("entry_score %0d, expected %0d (id %h)",
                                 data[33:26], w.entry_score, w.entry_id));
            if (data[37:34] !== w.position)
                report($sformatf("position %0d, expected %0d (id %h)",
                                 data[37:34], w.position, w.entry_id));
            if (data[42:38] !== w.entry_count)
                report($sformatf("entry_count %0d, expected %0d", data[42:38], w.entry_count));
            if (data[43] !== w.valid_res)
                report($sformatf("valid_res %b, expected %b", data[43], w.valid_res));
            if (data[47:44] !== 4'b0)
                report($sformatf("pad bits %b, expected zero", data[47:44]));
            if (last !== w.last)
                report($sformatf("tlast %b, expected %b", last, w.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;

    table_shadow shadow = new();
    bit          quiet  = 1'b0;
    int          cycle_count = 0;
    id_t         id_pool[POOL_SIZE];

    sorted_keyed_score_table_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random back-pressure bursts, none once quiet.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Output monitor: values are stable mid-cycle, so a transfer is seen at the falling edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
                shadow.check_result(m_tdata, m_tlast);
        end
    end

    task automatic issue_command(cmd_t cmd, id_t id, score_t score);
        bit accepted;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {score, id};
        s_tuser  <= cmd;
        do
        begin
            @(negedge clk);
            accepted = s_tready;
            @(posedge clk);
        end
        while (!accepted);
        shadow.note_command(cmd, id, score);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic id_t pick_id();
        if ($urandom_range(0, 9) == 0) return id_t'($urandom());
        return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic score_t pick_score();
        // narrow band now and then to provoke ties
        if ($urandom_range(0, 2) == 0) return score_t'($urandom_range(100, 103));
        return score_t'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int   phase;
        int   roll;
        cmd_t cmd;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_INSERT;

        id_pool[0] = 24'h000000;
        id_pool[1] = 24'hFFFFFF;
        id_pool[2] = 24'h5A5A5A;
        for (int i = 3; i < POOL_SIZE; i++) id_pool[i] = id_t'($urandom());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, misses, extremes, tie at the head, fill to capacity
        issue_command(CMD_DUMP,   24'h123456, 8'h00);
        issue_command(CMD_UPDATE, id_pool[1], 8'h10);
        issue_command(CMD_DELETE, id_pool[0], 8'h00);
        issue_command(CMD_INSERT, id_pool[0], 8'h00);
        issue_command(CMD_INSERT, id_pool[1], 8'hFF);
        issue_command(CMD_INSERT, id_pool[1], 8'h01);
        issue_command(CMD_INSERT, id_pool[2], 8'hFF);
        for (int k = 3; k < CAPACITY; k++)
            issue_command(CMD_INSERT, id_pool[k], pick_score());
        issue_command(CMD_INSERT, id_pool[CAPACITY], 8'h80);
        issue_command(CMD_INSERT, id_pool[5], 8'h80);
        issue_command(CMD_DUMP,   24'hFFFFFF, 8'hFF);
        issue_command(CMD_UPDATE, id_pool[0], 8'hFF);
        issue_command(CMD_DELETE, id_pool[1], 8'h00);
        issue_command(CMD_DUMP,   24'h000000, 8'h00);

        // random: phases bias toward shrinking, growing and churn
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == RAND_ITEMS / 2) wait_drained();
            if (n == RAND_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            phase = ((n / 40) + 2) % 3;
            roll  = $urandom_range(0, 99);
            case (phase)
                0: cmd = (roll < 60) ? CMD_INSERT : (roll < 75) ? CMD_UPDATE :
                         (roll < 90) ? CMD_DELETE : CMD_DUMP;
                1: cmd = (roll < 35) ? CMD_INSERT : (roll < 60) ? CMD_UPDATE :
                         (roll < 88) ? CMD_DELETE : CMD_DUMP;
                default: cmd = (roll < 20) ? CMD_INSERT : (roll < 40) ? CMD_UPDATE :
                               (roll < 88) ? CMD_DELETE : CMD_DUMP;
            endcase
            issue_command(cmd, pick_id(), pick_score());
        end

        wait_drained();
        repeat (DRAIN) @(posedge clk);
        if (shadow.pending_results.size() != 0)
            shadow.report($sformatf("%0d results never arrived", shadow.pending_results.size()));

        $display("covered %0d inserts, %0d updates, %0d deletes, %0d dumps; %0d results checked",
                 shadow.per_cmd[CMD_INSERT], shadow.per_cmd[CMD_UPDATE],
                 shadow.per_cmd[CMD_DELETE], shadow.per_cmd[CMD_DUMP], shadow.checked);
        $display("table peaked at %0d of %0d entries, %0d inserts refused as full",
                 shadow.peak, CAPACITY, shadow.full_hits);
        if (shadow.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
